### src/ecef_pkg.sv
// Package for the ECEF to latitude/longitude converter.
// Holds the CORDIC arctangent function, fixed-point constants and the stage word type.
// No dependencies.
`default_nettype none
package ecef_pkg;

	localparam int COORD_BITS = 28;
	localparam int ANG_W = 64;
	localparam int VEC_W = 64;
	localparam logic signed [ANG_W-1:0] PI4_Q60 = 64'sh0C90FDAA22168C23;
	localparam logic [33:0] GAIN_Q32 = 34'd7072781453;
	localparam logic signed [63:0] DEG_SCALE_Q4 = 64'sd916732472;
	localparam logic signed [63:0] LAT_LIMIT = 64'sd90000000;
	localparam logic signed [63:0] LON_LIMIT = 64'sd180000000;

	function automatic logic signed [ANG_W-1:0] atan_pow2(input int i);
		logic signed [ANG_W-1:0] sum;
		int e;
		logic [63:0] term;
		sum = '0;
		if (i == 0) begin
			return PI4_Q60;
		end
		for (int k = 0; k < 31; k++) begin
			e = i * (2 * k + 1);
			if (e <= 60) begin
				term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
				if (k % 2 == 1) begin
					sum = sum - $signed(term);
				end else begin
					sum = sum + $signed(term);
				end
			end
		end
		return sum;
	endfunction

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] ang;
		logic signed [VEC_W-1:0] z;
		logic                    fix;
	} cordic_word_t;

endpackage
`default_nettype wire

### src/ecef_to_lat_lon_unit.sv
// Throughput: one position per cycle; the unrolled CORDIC chain of both
// passes is the pipeline, and input ready follows output ready in the same cycle.
// The whole pipeline advances when the output register is free or taken.
// Reset clears all valid bits asynchronously; data registers are not reset.
`default_nettype none
module ecef_to_lat_lon_unit #(
	parameter int CORDIC_STAGES = 28
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// pos_x [27:0], pos_y [55:28], pos_z [83:56]
	input  wire logic [87:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// lat_microdeg [27:0], lon_microdeg [56:28], fix_valid [57]
	output logic [63:0]      m_axis_tdata
);
	import ecef_pkg::*;

	localparam int FRAC_BITS = 60 - COORD_BITS;
	localparam logic signed [VEC_W-1:0] GAIN = (FRAC_BITS <= 32) ?
		VEC_W'(GAIN_Q32 >> (32 - FRAC_BITS)) : VEC_W'(GAIN_Q32) << (FRAC_BITS - 32);

	logic en;
	logic signed [VEC_W-1:0] x_in, y_in, z_in;
	logic v_s1, v_s2, v_s3, v_s4, v_q;
	cordic_word_t w_s1, w_s2, w_s3;
	cordic_word_t w1;
	logic signed [VEC_W-1:0] lat_t_s4, lon_t_s4;
	logic signed [VEC_W-1:0] lat_m, lon_m;
	logic fix_s4;
	logic [63:0] data_q;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign x_in = VEC_W'($signed(s_axis_tdata[COORD_BITS-1:0]));
	assign y_in = VEC_W'($signed(s_axis_tdata[COORD_BITS +: COORD_BITS]));
	assign z_in = VEC_W'($signed(s_axis_tdata[2*COORD_BITS +: COORD_BITS]));

	// Stage 1: prescale and quadrant fold.
	always_comb begin
		w1.fix = !((x_in == 0 && y_in == 0) || (y_in == 0 && z_in == 0));
		w1.z = z_in;
		w1.x = x_in <<< FRAC_BITS;
		w1.y = y_in <<< FRAC_BITS;
		w1.ang = '0;
		if (x_in < 0) begin
			if (y_in >= 0) begin
				w1.x = y_in <<< FRAC_BITS;
				w1.y = -(x_in <<< FRAC_BITS);
				w1.ang = PI4_Q60 <<< 1;
			end else begin
				w1.x = -(y_in <<< FRAC_BITS);
				w1.y = x_in <<< FRAC_BITS;
				w1.ang = -(PI4_Q60 <<< 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			w_s1 <= w1;
		end
	end

	logic [CORDIC_STAGES:0] lv;
	cordic_word_t lw [CORDIC_STAGES+1];
	assign lv[0] = v_s1;
	assign lw[0] = w_s1;
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_lon
		ecef_cordic_stage #(.SHIFT(i)) u_stage (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(lv[i]), .in_word(lw[i]),
			.out_valid_s1(lv[i+1]), .out_word_s1(lw[i+1])
		);
	end

	// Gain multiply on z, start of the latitude pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= lv[CORDIC_STAGES];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			w_s2.x <= lw[CORDIC_STAGES].x;
			w_s2.y <= VEC_W'(lw[CORDIC_STAGES].z * GAIN);
			w_s2.ang <= '0;
			w_s2.z <= lw[CORDIC_STAGES].ang;
			w_s2.fix <= lw[CORDIC_STAGES].fix;
		end
	end

	logic [CORDIC_STAGES:0] av;
	cordic_word_t aw [CORDIC_STAGES+1];
	assign av[0] = v_s2;
	assign aw[0] = w_s2;
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_lat
		ecef_cordic_stage #(.SHIFT(i)) u_stage (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(av[i]), .in_word(aw[i]),
			.out_valid_s1(av[i+1]), .out_word_s1(aw[i+1])
		);
	end

	// Scale to microdegrees: multiply, then round and clamp; both are zero without a fix.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= av[CORDIC_STAGES];
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			w_s3 <= aw[CORDIC_STAGES];
			lat_t_s4 <= VEC_W'((w_s3.ang >>> 30) * DEG_SCALE_Q4);
			lon_t_s4 <= VEC_W'((w_s3.z >>> 30) * DEG_SCALE_Q4);
			fix_s4 <= w_s3.fix;
		end
	end

	always_comb begin
		lat_m = (lat_t_s4 + (64'sd1 <<< 33)) >>> 34;
		lon_m = (lon_t_s4 + (64'sd1 <<< 33)) >>> 34;
		if (lat_m > LAT_LIMIT) lat_m = LAT_LIMIT;
		if (lat_m < -LAT_LIMIT) lat_m = -LAT_LIMIT;
		if (lon_m > LON_LIMIT) lon_m = LON_LIMIT;
		if (lon_m < -LON_LIMIT) lon_m = -LON_LIMIT;
		if (!fix_s4) begin
			lat_m = '0;
			lon_m = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= {6'd0, fix_s4, lon_m[28:0], lat_m[27:0]};
		end
	end

	assign m_axis_tvalid = v_q;
	assign m_axis_tdata = data_q;
endmodule
`default_nettype wire

### src/ecef_cordic_stage.sv
// One registered CORDIC vectoring micro-rotation.
// Depends on ecef_pkg.
`default_nettype none
module ecef_cordic_stage #(
	parameter int SHIFT = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_valid,
	input  wire ecef_pkg::cordic_word_t in_word,
	output logic                       out_valid_s1,
	output ecef_pkg::cordic_word_t     out_word_s1
);
	import ecef_pkg::*;

	localparam logic signed [ANG_W-1:0] ATAN = atan_pow2(SHIFT);
	cordic_word_t nxt;

	always_comb begin
		nxt = in_word;
		if (in_word.y >= 0) begin
			nxt.x = in_word.x + (in_word.y >>> SHIFT);
			nxt.y = in_word.y - (in_word.x >>> SHIFT);
			nxt.ang = in_word.ang + ATAN;
		end else begin
			nxt.x = in_word.x - (in_word.y >>> SHIFT);
			nxt.y = in_word.y + (in_word.x >>> SHIFT);
			nxt.ang = in_word.ang - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (en) begin
			out_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word_s1 <= nxt;
		end
	end
endmodule
`default_nettype wire

### tb/ecef_to_lat_lon_checker.sv
// Checker for the ECEF to latitude/longitude converter.
// Watches both stream channels, predicts each output word with a CORDIC model
// and compares it with the block's output. Depends on nothing but the ports.
`timescale 1ns / 1ps
module ecef_to_lat_lon_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [87:0] s_axis_tdata,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [63:0] m_axis_tdata,
	output int               errors,
	output int               pending,
	output int               fixes,
	output int               no_fixes
);

	localparam int STAGES = 28;
	localparam int FRAC = 60 - 28;
	localparam longint PI4 = 64'sh0C90FDAA22168C23;
	localparam longint GAIN = 64'd7072781453 >> (32 - FRAC);

	typedef struct packed {
		logic               fix;
		logic signed [28:0] lon;
		logic signed [27:0] lat;
	} fix_word_t;

	longint atan_lut [STAGES];
	fix_word_t fix_queue [$];

	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint arctan_step(int i);
		longint sum;
		longint e;
		sum = 0;
		if (i == 0) begin
			return PI4;
		end
		for (int k = 0; k < 31; k++) begin
			e = i * (2 * k + 1);
			if (e <= 60) begin
				if (k % 2 == 1) begin
					sum -= longint'((64'd1 << (60 - e)) / (2 * k + 1));
				end else begin
					sum += longint'((64'd1 << (60 - e)) / (2 * k + 1));
				end
			end
		end
		return sum;
	endfunction

	function automatic longint rotate_to_axis(inout longint x, inout longint y, input longint a);
		longint dx, dy;
		for (int i = 0; i < STAGES; i++) begin
			dx = shr(y, i);
			dy = shr(x, i);
			if (y >= 0) begin
				x += dx;
				y -= dy;
				a += atan_lut[i];
			end else begin
				x -= dx;
				y += dy;
				a -= atan_lut[i];
			end
		end
		return a;
	endfunction

	function automatic longint to_microdeg(longint a, longint lim);
		longint m;
		m = shr(shr(a, 30) * 916732472 + (longint'(1) <<< 33), 34);
		if (m > lim) m = lim;
		if (m < -lim) m = -lim;
		return m;
	endfunction

	function automatic fix_word_t convert_position(logic [87:0] d);
		fix_word_t r;
		longint x, y, z, xs, ys, t, lon, lat, zk;
		x = longint'($signed(d[27:0]));
		y = longint'($signed(d[55:28]));
		z = longint'($signed(d[83:56]));
		r = '0;
		if ((x == 0 && y == 0) || (y == 0 && z == 0)) begin
			return r;
		end
		xs = x <<< FRAC;
		ys = y <<< FRAC;
		lon = 0;
		if (xs < 0) begin
			if (ys >= 0) begin
				t = xs; xs = ys; ys = -t; lon = 2 * PI4;
			end else begin
				t = xs; xs = -ys; ys = t; lon = -2 * PI4;
			end
		end
		lon = rotate_to_axis(xs, ys, lon);
		zk = z * GAIN;
		lat = rotate_to_axis(xs, zk, 0);
		r.lat = 28'(to_microdeg(lat, 90000000));
		r.lon = 29'(to_microdeg(lon, 180000000));
		r.fix = 1'b1;
		return r;
	endfunction

	initial begin
		for (int i = 0; i < STAGES; i++) begin
			atan_lut[i] = arctan_step(i);
		end
		errors = 0;
		pending = 0;
		fixes = 0;
		no_fixes = 0;
	end

	always @(posedge clk) begin
		fix_word_t want, got;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			fix_queue.push_back(convert_position(s_axis_tdata));
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[57:0];
			if (fix_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected word %h", $time, got);
			end else begin
				want = fix_queue.pop_front();
				if (got.fix) fixes++; else no_fixes++;
				if (got.lat !== want.lat) begin
					errors++;
					$display("%0t: lat expected %0d actual %0d", $time, want.lat, got.lat);
				end
				if (got.lon !== want.lon) begin
					errors++;
					$display("%0t: lon expected %0d actual %0d", $time, want.lon, got.lon);
				end
				if (got.fix !== want.fix) begin
					errors++;
					$display("%0t: fix expected %0b actual %0b", $time, want.fix, got.fix);
				end
			end
		end
		pending = fix_queue.size();
	end

endmodule

### tb/ecef_to_lat_lon_unit_test.sv
// Testbench top for the ECEF to latitude/longitude converter.
// Drives positions into the block and stalls its output; checking is done by
// ecef_to_lat_lon_checker.
`timescale 1ns / 1ps
module ecef_to_lat_lon_unit_test;

	localparam int LATENCY = 2 * 28 + 5;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        calm = 1'b0;
	logic        hold_off = 1'b0;
	logic        done = 1'b0;
	int          errors, pending, fixes, no_fixes;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	ecef_to_lat_lon_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	ecef_to_lat_lon_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.errors(errors), .pending(pending), .fixes(fixes), .no_fixes(no_fixes)
	);

	function automatic logic [27:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 28'sh8000000;
			1: return 28'sh7FFFFFF;
			2: return '0;
			3: return 28'($signed($urandom_range(0, 20)) - 10);
			4, 5: return 28'($signed($urandom_range(0, 128000000)) - 64000000);
			default: return 28'($urandom);
		endcase
	endfunction

	task automatic send_word(input logic [27:0] x, input logic [27:0] y, input logic [27:0] z);
		while (!calm && $urandom_range(0, 99) < 24) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, z, y, x};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	always @(posedge clk) begin
		if (hold_off) begin
			m_axis_tready <= 1'b0;
		end else if (calm) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= 24);
		end
	end

	initial begin
		logic [27:0] edge_vals [5];
		edge_vals = '{28'sh8000000, 28'sh7FFFFFF, 28'd0, 28'd1, 28'hFFFFFFF};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 5; i++) begin
			for (int j = 0; j < 5; j++) begin
				send_word(edge_vals[i], edge_vals[j], edge_vals[(i + j) % 5]);
			end
		end
		for (int n = 0; n < 1550; n++) begin
			if (n == 300) calm <= 1'b1;
			if (n == 500) calm <= 1'b0;
			if (n == 700) begin
				hold_off <= 1'b1;
				fork
					begin
						repeat (200) @(posedge clk);
						hold_off <= 1'b0;
					end
				join_none
			end
			send_word(rand_coord(), rand_coord(), rand_coord());
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		done <= 1'b1;
	end

	initial begin
		wait (done);
		$display("Converted %0d positions with a fix and %0d without one,", fixes, no_fixes);
		$display("including field extremes, input and output stalls and a long hold-off.");
		if (errors == 0) begin
			$display("ecef_to_lat_lon_unit_test OK");
		end else begin
			$display("ecef_to_lat_lon_unit_test NOT OK");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("ecef_to_lat_lon_unit_test NOT OK");
		$finish;
	end

endmodule

### files.f
src/ecef_pkg.sv
src/ecef_cordic_stage.sv
src/ecef_to_lat_lon_unit.sv
tb/ecef_to_lat_lon_checker.sv
tb/ecef_to_lat_lon_unit_test.sv
